/* hdl/ibmw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibmw_pkg - shared types and constants of the block map walker
// Widths, map geometry, command and result codes, queue entry layout.
// ----------------------------------------------------------------------------
package ibmw_pkg;

	localparam int DIRECT_COUNT = 12;
	localparam int MAX_LEVELS   = 6;
	localparam int BLOCK_BYTES  = 4096;
	localparam int FIFO_ENTRIES = 4;

	localparam int BLOCK_SHIFT  = $clog2(BLOCK_BYTES);
	localparam int WORD_SHIFT   = 3;
	localparam int DIGIT_BITS   = BLOCK_SHIFT - WORD_SHIFT;
	localparam int WORD_W       = 64;
	localparam int IMAGE_W      = 49;
	localparam int ADDR_W       = 48;
	localparam int LIMIT_W      = IMAGE_W - BLOCK_SHIFT;
	localparam int ADDR_HI_W    = ADDR_W - BLOCK_SHIFT;
	localparam int LEVEL_W      = 3;
	localparam int REM_W        = DIGIT_BITS * MAX_LEVELS;
	localparam int SHIFT_W      = $clog2(REM_W + 1);
	localparam int DIGIT_IDX_W  = $clog2(MAX_LEVELS);
	localparam int INODE_BYTES  = (DIRECT_COUNT + MAX_LEVELS) * (1 << WORD_SHIFT);

	localparam logic CMD_REQUEST  = 1'b0;
	localparam logic CMD_RESPONSE = 1'b1;
	localparam logic KIND_READ    = 1'b0;
	localparam logic KIND_DONE    = 1'b1;

	typedef logic [MAX_LEVELS+1:0][WORD_W-1:0] base_tbl_t;
	typedef logic [MAX_LEVELS-1:0][DIGIT_BITS-1:0] digits_t;

	// first logical block of each level, entry zero for the direct pointers
	function automatic base_tbl_t level_bases();
		base_tbl_t tbl;
		tbl[0] = '0;
		tbl[1] = WORD_W'(DIRECT_COUNT);
		for (int l = 2; l <= MAX_LEVELS + 1; l++) begin
			tbl[l] = tbl[l-1] + (WORD_W'(1) << (DIGIT_BITS * (l - 1)));
		end
		return tbl;
	endfunction

	localparam base_tbl_t LEVEL_BASES = level_bases();

	typedef struct packed {
		logic              command;
		logic [WORD_W-1:0] logical_block;
		logic [WORD_W-1:0] inode_blk;
		logic [WORD_W-1:0] read_data;
	} in_item_t;

	typedef struct packed {
		logic              result_kind;
		logic [ADDR_W-1:0] read_address;
		logic [WORD_W-1:0] physical_block;
		logic              found;
	} out_item_t;

	typedef logic [IMAGE_W-1:0] cfg_item_t;

	typedef struct packed {
		logic                  command;
		logic                  start_bad;
		logic [LEVEL_W-1:0]    level;
		digits_t               digits;
		logic [ADDR_HI_W-1:0]  addr_hi;
		logic [DIGIT_BITS-1:0] slot;
		logic [WORD_W-1:0]     word;
		logic                  word_null;
		logic                  word_fit;
	} q_item_t;

endpackage

/* hdl/ibmw_chan_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibmw_chan_if - valid/ready channel
// Carries one payload of type T per request.
// ----------------------------------------------------------------------------
interface ibmw_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hdl/ibmw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibmw_front - request classifier
// Holds the image limits, finds level, digits, slot and bounds of each
// request in two stages and hands the classified entry to the queue.
// ----------------------------------------------------------------------------
module ibmw_front (
	input  logic              clk,
	input  logic              arst_n,
	ibmw_chan_if.sink         cfg,
	ibmw_chan_if.sink         item,
	output logic              push_valid,
	input  logic              push_ready,
	output ibmw_pkg::q_item_t push_data
);
	import ibmw_pkg::*;

	logic                    inode_ok_q;
	logic                    blk_ok_q;
	logic [LIMIT_W-1:0]      inode_lim_q;
	logic [LIMIT_W-1:0]      blk_lim_q;
	logic [IMAGE_W-1:0]      inode_diff;
	logic [IMAGE_W-1:0]      blk_diff;

	logic [MAX_LEVELS+1:1]   ge;
	logic [LEVEL_W-1:0]      level_c;
	logic                    inode_fit_c;
	logic                    word_fit_c;

	logic                    valid_s1;
	in_item_t                item_s1;
	logic [LEVEL_W-1:0]      level_s1;
	logic                    lvl_bad_s1;
	logic                    inode_fit_s1;
	logic                    word_fit_s1;
	logic                    adv_s1;

	logic [WORD_W-1:0]       rem;
	logic [REM_W-1:0]        aligned;
	logic [SHIFT_W-1:0]      sh;

	// limits per span, precomputed at configuration time
	assign cfg.ready  = 1'b1;
	assign inode_diff = cfg.data - IMAGE_W'(INODE_BYTES);
	assign blk_diff   = cfg.data - IMAGE_W'(BLOCK_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inode_ok_q  <= 1'b0;
			blk_ok_q    <= 1'b0;
			inode_lim_q <= '0;
			blk_lim_q   <= '0;
		end else if (cfg.valid && cfg.ready) begin
			inode_ok_q  <= cfg.data >= IMAGE_W'(INODE_BYTES);
			blk_ok_q    <= cfg.data >= IMAGE_W'(BLOCK_BYTES);
			inode_lim_q <= inode_diff[IMAGE_W-1:BLOCK_SHIFT];
			blk_lim_q   <= blk_diff[IMAGE_W-1:BLOCK_SHIFT];
		end
	end

	// stage 1: level search and bounds checks
	always_comb begin
		for (int l = 1; l <= MAX_LEVELS + 1; l++) begin
			ge[l] = item.data.logical_block >= LEVEL_BASES[l];
		end
		level_c = '0;
		for (int l = 1; l <= MAX_LEVELS; l++) begin
			if (ge[l]) begin
				level_c = LEVEL_W'(l);
			end
		end
	end

	assign inode_fit_c = inode_ok_q && (item.data.inode_blk[WORD_W-1:LIMIT_W] == '0)
		&& (item.data.inode_blk[LIMIT_W-1:0] <= inode_lim_q);
	assign word_fit_c  = blk_ok_q && (item.data.read_data[WORD_W-1:LIMIT_W] == '0)
		&& (item.data.read_data[LIMIT_W-1:0] <= blk_lim_q);

	assign adv_s1     = !valid_s1 || push_ready;
	assign item.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item.valid) begin
			item_s1      <= item.data;
			level_s1     <= level_c;
			lvl_bad_s1   <= ge[MAX_LEVELS+1];
			inode_fit_s1 <= inode_fit_c;
			word_fit_s1  <= word_fit_c;
		end
	end

	// stage 2: index digits and inode word address
	assign rem     = item_s1.logical_block - LEVEL_BASES[level_s1];
	assign sh      = SHIFT_W'(DIGIT_BITS * (MAX_LEVELS - int'(level_s1)));
	assign aligned = rem[REM_W-1:0] << sh;

	always_comb begin
		push_data           = '0;
		push_data.command   = item_s1.command;
		push_data.start_bad = lvl_bad_s1 || !inode_fit_s1;
		push_data.level     = level_s1;
		for (int i = 0; i < MAX_LEVELS; i++) begin
			push_data.digits[i] = aligned[REM_W-1-DIGIT_BITS*i -: DIGIT_BITS];
		end
		if (item_s1.command == CMD_REQUEST) begin
			push_data.addr_hi = item_s1.inode_blk[ADDR_HI_W-1:0];
		end else begin
			push_data.addr_hi = item_s1.read_data[ADDR_HI_W-1:0];
		end
		if (level_s1 == '0) begin
			push_data.slot = item_s1.logical_block[DIGIT_BITS-1:0];
		end else begin
			push_data.slot = DIGIT_BITS'(DIRECT_COUNT - 1) + DIGIT_BITS'(level_s1);
		end
		push_data.word      = item_s1.read_data;
		push_data.word_null = &item_s1.read_data;
		push_data.word_fit  = word_fit_s1;
	end

	assign push_valid = valid_s1;

endmodule

/* hdl/ibmw_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibmw_queue - classified request queue
// Small first-in first-out buffer between the front and the back part.
// ----------------------------------------------------------------------------
module ibmw_queue #(
	parameter int DEPTH = ibmw_pkg::FIFO_ENTRIES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  ibmw_pkg::q_item_t push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output ibmw_pkg::q_item_t pop_data
);
	import ibmw_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_item_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count missed a pop");
`endif

endmodule

/* hdl/ibmw_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibmw_back - walk sequencer
// Keeps the walk state, turns each queued request into a word read or a
// finished translation, and holds the result in an output register.
// ----------------------------------------------------------------------------
module ibmw_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	output logic              head_ready,
	input  ibmw_pkg::q_item_t head,
	ibmw_chan_if.source       result
);
	import ibmw_pkg::*;

	localparam logic [WORD_SHIFT-1:0] WORD_PAD = '0;

	logic                   busy_q;
	logic                   await_q;
	logic [LEVEL_W-1:0]     level_q;
	logic [LEVEL_W-1:0]     depth_q;
	digits_t                digits_q;
	logic                   out_valid_q;
	out_item_t              out_q;

	logic                   pop;
	logic                   emit;
	logic                   digits_we;
	logic                   busy_d;
	logic                   await_d;
	logic [LEVEL_W-1:0]     level_d;
	logic [LEVEL_W-1:0]     depth_d;
	logic [DIGIT_IDX_W-1:0] idx;
	out_item_t              res;

	assign head_ready = !out_valid_q || result.ready;
	assign pop        = head_valid && head_ready;

	assign idx = (depth_q < LEVEL_W'(MAX_LEVELS)) ? DIGIT_IDX_W'(depth_q)
		: DIGIT_IDX_W'(depth_q - LEVEL_W'(MAX_LEVELS));

	always_comb begin
		emit      = 1'b0;
		digits_we = 1'b0;
		busy_d    = busy_q;
		await_d   = await_q;
		level_d   = level_q;
		depth_d   = depth_q;
		res       = '0;
		if (head.command == CMD_REQUEST) begin
			digits_we = 1'b1;
			emit      = 1'b1;
			if (head.start_bad) begin
				busy_d             = 1'b0;
				await_d            = 1'b0;
				res.result_kind    = KIND_DONE;
				res.physical_block = '1;
			end else begin
				busy_d           = 1'b1;
				await_d          = 1'b1;
				level_d          = head.level;
				depth_d          = '0;
				res.result_kind  = KIND_READ;
				res.read_address = {head.addr_hi, head.slot, WORD_PAD};
			end
		end else if (busy_q) begin
			emit = 1'b1;
			if (head.word_null) begin
				busy_d             = 1'b0;
				await_d            = 1'b0;
				res.result_kind    = KIND_DONE;
				res.physical_block = '1;
			end else if ((await_q && level_q == '0) || (!await_q && depth_q >= level_q)) begin
				busy_d             = 1'b0;
				await_d            = 1'b0;
				res.result_kind    = KIND_DONE;
				res.physical_block = head.word;
				res.found          = 1'b1;
			end else if (!head.word_fit) begin
				busy_d             = 1'b0;
				await_d            = 1'b0;
				res.result_kind    = KIND_DONE;
				res.physical_block = '1;
			end else begin
				await_d          = 1'b0;
				depth_d          = depth_q + 1'b1;
				res.result_kind  = KIND_READ;
				res.read_address = {head.word[ADDR_HI_W-1:0], digits_q[idx], WORD_PAD};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			await_q     <= 1'b0;
			level_q     <= '0;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q  <= busy_d;
				await_q <= await_d;
				level_q <= level_d;
				depth_q <= depth_d;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && digits_we) begin
			digits_q <= head.digits;
		end
		if (pop && emit) begin
			out_q <= res;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

`ifndef ASSERT_OFF
	a_depth_le_level: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> depth_q <= level_q)
		else $error("walk depth passed its level");
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> level_q <= LEVEL_W'(MAX_LEVELS))
		else $error("walk level out of range");
	a_await_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !await_q)
		else $error("inode word awaited while idle");
	a_await_depth: assert property (@(posedge clk) disable iff (!arst_n)
		await_q |-> depth_q == '0)
		else $error("walk descended before the inode word");
`endif

endmodule

/* hdl/indirect_block_map_walker_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indirect_block_map_walker_top - inode block map walker
// Maps a file's logical block to a physical block through direct and
// indirect pointer trees, issuing pointer word reads one at a time.
// ----------------------------------------------------------------------------
// usage
//   cfg    : image size in bytes, writable while the walker is idle
//   item   : command 0 starts a translation, command 1 returns a read word
//   result : kind 0 asks for the 64-bit word at read_address, kind 1 ends
//            the translation with physical_block and found
//   every request gives at most one result; a read word that arrives with
//   no walk running gives none, a new translation drops the running walk
//   each request passes the classifier register, the queue and the output register before its result is valid
//   throughput: one request per cycle while the receiver takes results, set by the single walk sequencer
//   a two-stage classifier feeds a FIFO_ENTRIES entry queue, so requests
//   keep flowing while a result waits for the receiver
//   when the receiver stalls the queue fills and item.ready drops
//   reset clears the walk, the queue, the output register and sets the
//   image size to zero, so every translation ends as not found until cfg
//   is written
// ----------------------------------------------------------------------------
module indirect_block_map_walker_top #(
	parameter int FIFO_ENTRIES = ibmw_pkg::FIFO_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	ibmw_chan_if.sink   cfg,
	ibmw_chan_if.sink   item,
	ibmw_chan_if.source result
);
	import ibmw_pkg::*;

	logic    push_valid;
	logic    push_ready;
	q_item_t push_data;
	logic    head_valid;
	logic    head_ready;
	q_item_t head;

	ibmw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	ibmw_queue #(
		.DEPTH (FIFO_ENTRIES)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (head_valid),
		.pop_ready  (head_ready),
		.pop_data   (head)
	);

	ibmw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_ready (head_ready),
		.head       (head),
		.result     (result)
	);

endmodule
